/* hdl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  // Code point and result value width.
  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ReplacementChar = 21'h00FFFD;
  localparam logic [CpW-1:0] SupplementaryBase = 21'h010000;
  localparam logic [CpW-1:0] HighSurrogateBase = 21'h00D800;
  localparam logic [CpW-1:0] LowSurrogateBase = 21'h00DC00;

  // Bounds for continuation bytes.
  localparam logic [7:0] ContLow = 8'h80;
  localparam logic [7:0] ContHigh = 8'hBF;
  localparam logic [7:0] AfterE0Low = 8'hA0;
  localparam logic [7:0] AfterEdHigh = 8'h9F;
  localparam logic [7:0] AfterF0Low = 8'h90;
  localparam logic [7:0] AfterF4High = 8'h8F;

  // Output format register codes.
  localparam logic FmtCodePoint = 1'b0;
  localparam logic FmtUtf16 = 1'b1;

  // Sequence state carried between bytes.
  typedef struct packed {
    logic [CpW-1:0] partial_code;
    logic [1:0]     bytes_pending;
    logic [7:0]     lower_bound;
    logic [7:0]     upper_bound;
  } seq_state_t;

  localparam seq_state_t SeqReset = '{
    partial_code:  '0,
    bytes_pending: 2'd0,
    lower_bound:   ContLow,
    upper_bound:   ContHigh
  };

  // One result item as it is queued for the output.
  typedef struct packed {
    logic [CpW-1:0] value;
    logic           replaced;
    logic           string_done;
    logic           run_last;
  } result_t;

endpackage : utf8d_pkg

`default_nettype wire

/* hdl/utf8d_decode.sv */
// Single-pass decode step: one UTF-8 byte and the sequence state give up to two results.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode
  import utf8d_pkg::*;
(
  input  var seq_state_t  st_i,
  input  wire             fmt_i,
  input  wire  [7:0]      byte_i,
  input  wire             eos_i,
  output seq_state_t      st_o,
  output result_t         unit0_o,
  output result_t         unit1_o,
  output logic [1:0]      n_units_o
);

  // Outcome of taking a byte as the start of a sequence.
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] cp;
    logic           replaced;
    seq_state_t     st;
  } lead_t;

  function automatic lead_t take_lead(input logic [7:0] b);
    lead_t r;
    r.emit = 1'b0;
    r.cp = '0;
    r.replaced = 1'b0;
    r.st = SeqReset;
    priority if (b <= 8'h7F) begin
      r.emit = 1'b1;
      r.cp = {13'd0, b};
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      r.st.bytes_pending = 2'd1;
      r.st.partial_code = {16'd0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      r.st.bytes_pending = 2'd2;
      r.st.partial_code = {17'd0, b[3:0]};
      if (b == 8'hE0) r.st.lower_bound = AfterE0Low;
      if (b == 8'hED) r.st.upper_bound = AfterEdHigh;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      r.st.bytes_pending = 2'd3;
      r.st.partial_code = {18'd0, b[2:0]};
      if (b == 8'hF0) r.st.lower_bound = AfterF0Low;
      if (b == 8'hF4) r.st.upper_bound = AfterF4High;
    end else begin
      r.emit = 1'b1;
      r.cp = ReplacementChar;
      r.replaced = 1'b1;
    end
    return r;
  endfunction

  lead_t          lead;
  seq_state_t     nxt;
  logic [CpW-1:0] cp0, cp1;
  logic           rep0, rep1;
  logic [1:0]     ncp;
  logic           out_of_bounds;
  logic [CpW-1:0] acc;
  logic [19:0]    adj;
  logic           split;

  // Sequence tracking: collect up to two code points for this byte.
  always_comb begin
    lead = take_lead(byte_i);
    nxt = st_i;
    cp0 = '0;
    cp1 = '0;
    rep0 = 1'b0;
    rep1 = 1'b0;
    ncp = 2'd0;
    out_of_bounds = (byte_i < st_i.lower_bound) || (byte_i > st_i.upper_bound);
    acc = {st_i.partial_code[CpW-7:0], byte_i[5:0]};

    if (st_i.bytes_pending == 2'd0) begin
      nxt = lead.st;
      if (lead.emit) begin
        cp0 = lead.cp;
        rep0 = lead.replaced;
        ncp = 2'd1;
      end
    end else if (out_of_bounds) begin
      // The sequence is broken: replace it, then take the byte as a new lead.
      cp0 = ReplacementChar;
      rep0 = 1'b1;
      ncp = 2'd1;
      nxt = lead.st;
      if (lead.emit) begin
        cp1 = lead.cp;
        rep1 = lead.replaced;
        ncp = 2'd2;
      end
    end else begin
      nxt.lower_bound = ContLow;
      nxt.upper_bound = ContHigh;
      nxt.bytes_pending = st_i.bytes_pending - 2'd1;
      nxt.partial_code = acc;
      if (st_i.bytes_pending == 2'd1) begin
        nxt.partial_code = '0;
        cp0 = acc;
        ncp = 2'd1;
      end
    end

    // An unfinished sequence at the end of a string is replaced.
    if (eos_i) begin
      if (nxt.bytes_pending != 2'd0) begin
        if (ncp == 2'd0) begin
          cp0 = ReplacementChar;
          rep0 = 1'b1;
          ncp = 2'd1;
        end else if (ncp == 2'd1) begin
          cp1 = ReplacementChar;
          rep1 = 1'b1;
          ncp = 2'd2;
        end
      end
      nxt = SeqReset;
    end
  end

  // Result formation. Only a lone completed code point can be supplementary,
  // so the surrogate split looks at the first code point alone.
  always_comb begin
    adj = cp0[19:0] - SupplementaryBase[19:0];
    split = (fmt_i == FmtUtf16) && (cp0 >= SupplementaryBase);
    unit0_o = '0;
    unit1_o = '0;
    if (split) begin
      unit0_o.value = HighSurrogateBase + {11'd0, adj[19:10]};
      unit0_o.replaced = rep0;
      unit1_o.value = LowSurrogateBase + {11'd0, adj[9:0]};
      unit1_o.replaced = rep0;
      n_units_o = 2'd2;
    end else begin
      unit0_o.value = cp0;
      unit0_o.replaced = rep0;
      unit1_o.value = cp1;
      unit1_o.replaced = rep1;
      n_units_o = ncp;
    end
    unit0_o.run_last = (n_units_o == 2'd1);
    unit0_o.string_done = eos_i && (n_units_o == 2'd1);
    unit1_o.run_last = 1'b1;
    unit1_o.string_done = eos_i;
    st_o = nxt;
  end

endmodule : utf8d_decode

`default_nettype wire

/* hdl/utf8_stream_decoder_top.sv */
// UTF-8 stream decoder top level: input handshake, sequence state, result queue.
//
// Usage: UTF-8 bytes enter on the s_axis channel, one per item, with tlast
// marking the final byte of a string. Results leave on the m_axis channel:
// tdata carries the code point (or a UTF-16 code unit), tuser the replaced
// and run_last flags, tlast the end of a string. Bad bytes give U+FFFD.
// The cfg channel writes the output format (0 code points, 1 UTF-16); it is
// always ready. It must be written by the user only while the block is idle;
// the block itself does not enforce it. Throughput: one byte per cycle while
// the queue has room; each byte is decoded combinationally into at most two
// results that go into a four-entry result queue. The output drains one result
// per cycle while the receiver is ready, so throughput is bounded by the output
// side when bytes give two results (surrogate pairs, replaced sequences).
// s_axis_tready is high while the queue has room for two results, so input
// is taken while earlier results still wait at the output.
// Reset clears the sequence state, empties the queue and selects code points.
// When the receiver stalls, the queue fills and s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_top
  import utf8d_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tlast,   // end_of_string
  // Result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] value, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [0] replaced, [1] run_last
  output logic        m_axis_tlast,   // string_done
  // Configuration
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i      // output_format
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW = $clog2(Depth);

  seq_state_t      state_q, state_d;
  logic            fmt_q;
  result_t         unit0, unit1;
  logic [1:0]      n_units;
  logic            in_fire, out_fire;
  result_t         queue_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (count_q <= (PtrW + 1)'(Depth - 2));

  // Decode step for the byte on the input.
  utf8d_decode u_decode (
    .st_i      (state_q),
    .fmt_i     (fmt_q),
    .byte_i    (s_axis_tdata),
    .eos_i     (s_axis_tlast),
    .st_o      (state_d),
    .unit0_o   (unit0),
    .unit1_o   (unit1),
    .n_units_o (n_units)
  );

  // Sequence state and output format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqReset;
      fmt_q <= FmtCodePoint;
    end else begin
      if (in_fire) state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) fmt_q <= cfg_data_i;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (in_fire && n_units != 2'd0) queue_q[wr_ptr_q] <= unit0;
    if (in_fire && n_units == 2'd2) queue_q[wr_ptr_q + PtrW'(1)] <= unit1;
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= wr_ptr_q + PtrW'(n_units);
      if (out_fire) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + (in_fire ? (PtrW + 1)'(n_units) : '0)
                         - (out_fire ? (PtrW + 1)'(1) : '0);
    end
  end

  // Output from the head of the queue.
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata = {3'd0, queue_q[rd_ptr_q].value};
  assign m_axis_tuser = {queue_q[rd_ptr_q].run_last, queue_q[rd_ptr_q].replaced};
  assign m_axis_tlast = queue_q[rd_ptr_q].string_done;

`ifndef SYNTHESIS
  // The fill count agrees with the pointer distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
    else $error("result queue count and pointers disagree");

  // The queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW + 1)'(Depth))
    else $error("result queue overflow");

  // The end of a string gives at least one result and clears the sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |-> (n_units != 2'd0))
    else $error("end of string gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (state_q == SeqReset))
    else $error("sequence state not cleared after end of string");
`endif

endmodule : utf8_stream_decoder_top

`default_nettype wire
